[hw/rtl/scfla_pkg.sv]
// Shared types and codes for the size-class free-list allocator.
// No dependencies; imported by the top level, size_class_free_list_allocator.
`default_nettype none

package scfla_pkg;

    localparam int ADDR_W = 17;
    localparam int SIZE_W = 12;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERSIZE = 2'd2,
        ST_ZERO     = 2'd3
    } status_t;

    typedef struct packed
    {
        op_t                op;
        logic [SIZE_W-1:0]  request_bytes;
        logic [ADDR_W-1:0]  block_address;
    } request_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]  granted_address;
        status_t            status;
    } result_t;

    // one free-list entry: list end is a cleared valid bit
    typedef struct packed
    {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
    } link_word_t;

endpackage

`default_nettype wire

[hw/rtl/scfla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module scfla_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/scfla_cdiv.sv]
// Unsigned division by a constant, as a multiply by a rounded-up reciprocal.
// Exact for every dividend of IN_W bits. No dependencies.
`default_nettype none

module scfla_cdiv #(
    parameter int DIVISOR = 8,
    parameter int IN_W    = 17
) (
    input  logic [IN_W-1:0] dividend,
    output logic [IN_W-1:0] quotient
);

    localparam int SH   = IN_W + $clog2(DIVISOR);
    localparam int MW   = SH + 1;
    localparam int PW   = IN_W + MW;
    localparam longint unsigned MULT =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [MW-1:0] mult_c;
    logic [PW-1:0] prod;

    assign mult_c   = MW'(MULT);
    assign prod     = PW'(dividend) * PW'(mult_c);
    assign quotient = prod[SH +: IN_W];

endmodule

`default_nettype wire

[hw/rtl/size_class_free_list_allocator.sv]
// Top level of the size-class free-list allocator: head and link memories,
// init sequencer and request control. Uses scfla_pkg, scfla_ram, scfla_cdiv.
`default_nettype none

// A request transfers when start is high and busy is low. Exactly one result
// follows, shown for a single cycle with done high; it cannot be held off.
// Free, zero-size, oversize and empty-list allocate requests are answered from
// state S_HEAD; an allocate that pops a block goes on to S_LINK: the class head
// is read from the head memory, then the popped block's link is read from the
// link memory before the head is written back. busy stays high until done,
// so a new request can transfer in the cycle that done is shown. After reset
// the link and head memories are filled by an init pass of one link entry per
// cycle over all LINK_DEPTH link entries (8704 at the default parameters), with
// busy high throughout.
module size_class_free_list_allocator #(
    parameter int GRANULE_BYTES       = 8,
    parameter int LARGEST_CLASS_BYTES = 128,
    parameter int BLOCKS_PER_CLASS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  scfla_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output scfla_pkg::result_t  result
);

    import scfla_pkg::*;

    localparam int NUM_CLASSES = LARGEST_CLASS_BYTES / GRANULE_BYTES;
    localparam int LINK_DEPTH  = BLOCKS_PER_CLASS * NUM_CLASSES * (NUM_CLASSES + 1) / 2;
    localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int LINK_AW     = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
    localparam int BLK_W       = $clog2(BLOCKS_PER_CLASS);
    localparam int WORD_W      = $bits(link_word_t);

    typedef enum logic [1:0]
    {
        S_INIT,
        S_IDLE,
        S_HEAD,
        S_LINK
    } state_t;

    state_t             state_reg;

    // init pass counters
    logic [LINK_AW-1:0] init_idx_reg;
    logic [ADDR_W-1:0]  init_addr_reg;
    logic [ADDR_W-1:0]  init_stride_reg;
    logic [CLS_W-1:0]   init_cls_reg;
    logic [CLS_W-1:0]   init_g_reg;
    logic [BLK_W-1:0]   init_i_reg;

    // captured request
    op_t                op_reg;
    logic [CLS_W-1:0]   cls_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LINK_AW-1:0] free_idx_reg;
    logic               free_ok_reg;
    logic               special_reg;
    status_t            special_status_reg;

    logic [ADDR_W-1:0]  blk_reg;
    logic               link_ok_reg;

    logic               done_reg;
    result_t            result_reg;

    // request decode
    logic [ADDR_W-1:0]  size_round;
    logic [ADDR_W-1:0]  q_size;
    logic [ADDR_W-1:0]  q_free;
    logic [ADDR_W-1:0]  q_head;
    logic               size_zero;
    logic               size_over;
    logic [CLS_W-1:0]   cls_c;

    // memory ports
    logic               head_we;
    logic [CLS_W-1:0]   head_waddr;
    link_word_t         head_wdata;
    link_word_t         head_rdata;
    logic               link_we;
    logic [LINK_AW-1:0] link_waddr;
    link_word_t         link_wdata;
    link_word_t         link_rdata;

    logic               init_blk_start;
    logic               init_last;

    assign size_round = ADDR_W'(request.request_bytes) + ADDR_W'(GRANULE_BYTES - 1);

    scfla_cdiv #(.DIVISOR(GRANULE_BYTES), .IN_W(ADDR_W)) u_size_div
    (
        .dividend (size_round),
        .quotient (q_size)
    );

    scfla_cdiv #(.DIVISOR(GRANULE_BYTES), .IN_W(ADDR_W)) u_free_div
    (
        .dividend (request.block_address),
        .quotient (q_free)
    );

    scfla_cdiv #(.DIVISOR(GRANULE_BYTES), .IN_W(ADDR_W)) u_head_div
    (
        .dividend (head_rdata.addr),
        .quotient (q_head)
    );

    assign size_zero = (request.request_bytes == '0);
    assign size_over = (32'(request.request_bytes) > 32'(LARGEST_CLASS_BYTES))
                    || (32'(q_size) > 32'(NUM_CLASSES));
    assign cls_c     = CLS_W'(q_size - ADDR_W'(1));

    assign init_blk_start = (init_g_reg == '0);
    assign init_last      = (init_i_reg == BLK_W'(BLOCKS_PER_CLASS - 1));

    scfla_ram #(.WIDTH(WORD_W), .DEPTH(NUM_CLASSES)) u_head_ram
    (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (cls_c),
        .rdata (head_rdata)
    );

    scfla_ram #(.WIDTH(WORD_W), .DEPTH(LINK_DEPTH)) u_link_ram
    (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (LINK_AW'(q_head)),
        .rdata (link_rdata)
    );

    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = cls_reg;
        head_wdata = '0;
        link_we    = 1'b0;
        link_waddr = free_idx_reg;
        link_wdata = head_rdata;
        unique case (state_reg)
            S_INIT:
            begin
                head_waddr = init_cls_reg;
                head_wdata = '{valid: 1'b1, addr: init_addr_reg};
                head_we    = init_blk_start && (init_i_reg == '0);
                link_we    = 1'b1;
                link_waddr = init_idx_reg;
                link_wdata = (init_blk_start && !init_last)
                           ? link_word_t'{valid: 1'b1, addr: init_addr_reg + init_stride_reg}
                           : '0;
            end
            S_HEAD:
            begin
                if (!special_reg && op_reg == OP_FREE)
                begin
                    head_we    = free_ok_reg;
                    head_wdata = '{valid: 1'b1, addr: addr_reg};
                    link_we    = free_ok_reg;
                end
            end
            S_LINK:
            begin
                head_we    = 1'b1;
                head_wdata = (link_ok_reg && link_rdata.valid) ? link_rdata : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            init_idx_reg    <= '0;
            init_addr_reg   <= '0;
            init_stride_reg <= ADDR_W'(GRANULE_BYTES);
            init_cls_reg    <= '0;
            init_g_reg      <= '0;
            init_i_reg      <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_INIT:
                begin
                    init_idx_reg  <= init_idx_reg + LINK_AW'(1);
                    init_addr_reg <= init_addr_reg + ADDR_W'(GRANULE_BYTES);
                    if (init_g_reg == init_cls_reg)
                    begin
                        init_g_reg <= '0;
                        if (init_last)
                        begin
                            init_i_reg      <= '0;
                            init_cls_reg    <= init_cls_reg + CLS_W'(1);
                            init_stride_reg <= init_stride_reg + ADDR_W'(GRANULE_BYTES);
                        end
                        else
                        begin
                            init_i_reg <= init_i_reg + BLK_W'(1);
                        end
                    end
                    else
                    begin
                        init_g_reg <= init_g_reg + CLS_W'(1);
                    end
                    if (32'(init_idx_reg) == 32'(LINK_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg             <= request.op;
                        cls_reg            <= cls_c;
                        addr_reg           <= request.block_address;
                        free_idx_reg       <= LINK_AW'(q_free);
                        free_ok_reg        <= (32'(q_free) < 32'(LINK_DEPTH));
                        special_reg        <= size_zero || size_over;
                        special_status_reg <= size_zero ? ST_ZERO : ST_OVERSIZE;
                        state_reg          <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    priority if (special_reg)
                    begin
                        done_reg                   <= 1'b1;
                        result_reg.granted_address <= '0;
                        result_reg.status          <= special_status_reg;
                        state_reg                  <= S_IDLE;
                    end
                    else if (op_reg == OP_FREE)
                    begin
                        done_reg                   <= 1'b1;
                        result_reg.granted_address <= '0;
                        result_reg.status          <= ST_OK;
                        state_reg                  <= S_IDLE;
                    end
                    else if (!head_rdata.valid)
                    begin
                        done_reg                   <= 1'b1;
                        result_reg.granted_address <= '0;
                        result_reg.status          <= ST_EMPTY;
                        state_reg                  <= S_IDLE;
                    end
                    else
                    begin
                        blk_reg     <= head_rdata.addr;
                        link_ok_reg <= (32'(q_head) < 32'(LINK_DEPTH));
                        state_reg   <= S_LINK;
                    end
                end
                S_LINK:
                begin
                    done_reg                   <= 1'b1;
                    result_reg.granted_address <= blk_reg;
                    result_reg.status          <= ST_OK;
                    state_reg                  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.granted_address == '0)
        else $error("address given with a failing status");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !head_we && !link_we)
        else $error("memory written while idle");

    a_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("request transfer not followed by busy");
`endif

endmodule

`default_nettype wire
